>>> rtl/feedforward_audio_compressor_assert.svh
// Assertion macros shared by the compressor checker.
`ifndef FEEDFORWARD_AUDIO_COMPRESSOR_ASSERT_SVH
`define FEEDFORWARD_AUDIO_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FFAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffac_pkg.sv
// Shared types, constants and tables of the feed-forward compressor.
`default_nettype none
package ffac_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CFG_RISE_COEF    = 8'd0;
    localparam logic [7:0] CFG_FALL_COEF    = 8'd1;
    localparam logic [7:0] CFG_THRESHOLD_DB = 8'd2;
    localparam logic [7:0] CFG_INV_RATIO    = 8'd3;

    localparam logic [24:0] RISE_COEF_RST    = 25'd76087;
    localparam logic [24:0] FALL_COEF_RST    = 25'd7609;
    localparam logic [15:0] THRESHOLD_DB_RST = 16'hEC00;
    localparam logic [16:0] INV_RATIO_RST    = 17'd32768;

    localparam logic [24:0] ONE_Q24 = 25'h1000000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [18:0] DB_PER_OCTAVE_Q16 = 19'd394566;
    localparam logic [13:0] OCTAVE_PER_DB_Q16 = 14'd10885;

    typedef struct packed {
        logic [24:0]        rise_coef;
        logic [24:0]        fall_coef;
        logic signed [15:0] threshold_db;
        logic [16:0]        inv_ratio;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [31:0]        envelope;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [15:0][31:0] exp_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry j holds 2^(2^-(j+1) - 1) in Q0.32.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] t;
        t = 64'h1_0000_0000;
        for (int j = 0; j < 16; j++)
        begin
            t = isqrt64(t << 31);
            tab[j] = t[31:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

>>> rtl/feedforward_audio_compressor.sv
// Top level of the feed-forward audio compressor: configuration registers and datapath.
//
// Feed-forward dynamic range compressor for signed Q1.23 samples. Each sample is
// squared into a Q0.32 power, a one-pole envelope follows that power with the rise
// or fall coefficient, and the envelope level (20*log10 of the envelope) above the
// Q8.8 dB threshold is scaled by (1 - inv_ratio) and turned back into a Q0.16 gain
// in [0,1] that multiplies the sample. The front end takes one sample at a time
// (accept, power, envelope update); it is limited by the envelope recurrence. The
// back end takes one entry at a time; in full, the gain computer runs a 16-step log2 by
// repeated squaring, then a 16-step product of 2^(2^-i - 1) factors. It skips to the
// output when the envelope is zero or the ratio is at most one, and when the level is
// at or below the threshold or the scaled excess rounds to zero; its sustained rate
// sets the block's throughput. A queue of QUEUE_DEPTH entries between the two ends
// lets the front keep accepting while the back works and while a finished result waits
// on out_stall. Configuration is to be written through cfg_we/cfg_index/cfg_data while
// the block is idle; the block does not enforce it. Indexes beyond three are dropped.
`default_nettype none
module feedforward_audio_compressor
    import ffac_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [24:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] sample_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [23:0]      sample_out,
    output logic [16:0]             gain
);

    cfg_t      cfg_reg;
    q_status_t q_stat;
    q_entry_t  push_entry, pop_entry;
    logic      push, pop;

    // Register writes: one register per transaction, unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_coef    <= RISE_COEF_RST;
            cfg_reg.fall_coef    <= FALL_COEF_RST;
            cfg_reg.threshold_db <= THRESHOLD_DB_RST;
            cfg_reg.inv_ratio    <= INV_RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RISE_COEF:    cfg_reg.rise_coef    <= cfg_data;
                CFG_FALL_COEF:    cfg_reg.fall_coef    <= cfg_data;
                CFG_THRESHOLD_DB: cfg_reg.threshold_db <= cfg_data[15:0];
                CFG_INV_RATIO:    cfg_reg.inv_ratio    <= cfg_data[16:0];
                default:          ;
            endcase
        end
    end

    // Front end: holds the envelope state, one sample at a time.
    ffac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue of sample and envelope pairs.
    ffac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    // Back end: gain computer and output register.
    ffac_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .gain       (gain)
    );

endmodule
`default_nettype wire

>>> rtl/ffac_front.sv
// Front end: accept samples, form power, update the envelope, push to the queue.
`default_nettype none
module ffac_front
    import ffac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] sample_in,
    input  wire q_status_t          q_stat,
    output logic                    push,
    output q_entry_t                push_entry
);

    typedef enum logic [1:0] {F_IDLE, F_POW, F_ENV} f_state_t;

    f_state_t           state_reg, state_next;
    logic signed [23:0] x_reg;
    logic [31:0]        power_reg, power_next;
    logic [31:0]        env_reg, env_next;
    logic [31:0]        last_reg;
    logic               rising_reg, rising_next;

    logic signed [47:0] sq;
    logic [24:0]        coef_sel, coef;
    logic [31:0]        env_gap;
    logic [56:0]        step_prod;
    logic [31:0]        step;

    always_comb
    begin
        sq = x_reg * x_reg;
        power_next = (sq[47:46] != 2'b00) ? 32'hFFFF_FFFF : sq[45:14];

        if (power_reg > last_reg)
            rising_next = 1'b1;
        else if (power_reg < last_reg)
            rising_next = 1'b0;
        else
            rising_next = rising_reg;

        coef_sel = rising_next ? cfg.rise_coef : cfg.fall_coef;
        coef = (coef_sel > ONE_Q24) ? ONE_Q24 : coef_sel;
        env_gap = (power_reg >= env_reg) ? power_reg - env_reg : env_reg - power_reg;
        step_prod = {25'd0, env_gap} * {32'd0, coef};
        step = step_prod[55:24];
        env_next = (power_reg >= env_reg) ? env_reg + step : env_reg - step;
    end

    assign in_stall = (state_reg != F_IDLE);
    assign push = (state_reg == F_ENV) && !q_stat.full;
    assign push_entry = '{sample: x_reg, envelope: env_next};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_POW;
            F_POW:   state_next = F_ENV;
            F_ENV:   if (!q_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            env_reg    <= 32'd0;
            last_reg   <= 32'd0;
            rising_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_IDLE && in_valid)
                x_reg <= sample_in;
            if (state_reg == F_POW)
                power_reg <= power_next;
            if (push)
            begin
                env_reg    <= env_next;
                last_reg   <= power_reg;
                rising_reg <= rising_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffac_queue.sv
// Short queue between the envelope front end and the gain back end.
`default_nettype none
module ffac_queue
    import ffac_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      pop_entry,
    output q_status_t     q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slots_reg[wr_ptr_reg] <= push_entry;
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffac_back.sv
// Back end: level in dB, gain computer, exponent, gain multiply and output register.
`default_nettype none
module ffac_back
    import ffac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire q_status_t   q_stat,
    input  wire q_entry_t    pop_entry,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [23:0] sample_out,
    output logic [16:0]      gain
);

    typedef enum logic [2:0] {
        B_IDLE, B_LOG, B_ATT, B_DIFF, B_EXC, B_EXP, B_SHIFT, B_OUT
    } b_state_t;

    b_state_t           state_reg;
    logic signed [23:0] x_reg;
    logic [4:0]         k_reg;
    logic [31:0]        m_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         cnt_reg;
    logic [24:0]        att_reg;
    logic [26:0]        excess_reg;
    logic [24:0]        e_reg;
    logic [32:0]        g_reg;
    logic [16:0]        gain_reg;
    logic               out_valid_reg;
    logic signed [23:0] sample_out_reg;
    logic [16:0]        gain_out_reg;

    logic [4:0]         lead;
    logic [31:0]        m_init;
    logic [63:0]        sq;
    logic [31:0]        m_next;
    logic [21:0]        neglog;
    logic [40:0]        att_prod;
    logic signed [26:0] diff;
    logic [16:0]        one_minus;
    logic [42:0]        exc_prod;
    logic [40:0]        e_prod;
    logic [64:0]        g_prod;
    logic [8:0]         shift_n;
    logic [32:0]        g_shift;
    logic signed [41:0] out_prod;
    logic signed [25:0] y;
    logic signed [23:0] y_sat;
    logic               out_free;

    always_comb
    begin
        lead = 5'd0;
        for (int b = 0; b < 32; b++)
            if (pop_entry.envelope[b]) lead = 5'(b);
        m_init = pop_entry.envelope << (5'd31 - lead);

        sq = {32'd0, m_reg} * {32'd0, m_reg};
        m_next = sq[63] ? sq[63:32] : sq[62:31];

        neglog = {6'd32 - {1'b0, k_reg}, 16'd0} - {6'd0, frac_reg};
        att_prod = {19'd0, neglog} * {22'd0, DB_PER_OCTAVE_Q16};

        diff = 27'sd0 - $signed({2'b00, att_reg})
             - $signed({{3{cfg.threshold_db[15]}}, cfg.threshold_db, 8'h00});
        one_minus = ONE_Q16 - cfg.inv_ratio;
        exc_prod = {17'd0, diff[25:0]} * {26'd0, one_minus};

        e_prod = {14'd0, excess_reg} * {27'd0, OCTAVE_PER_DB_Q16};

        g_prod = {32'd0, g_reg} * {33'd0, EXP_TAB[cnt_reg]};

        shift_n = e_reg[24:16];
        g_shift = g_reg >> shift_n[5:0];

        out_prod = x_reg * $signed({1'b0, gain_reg});
        y = out_prod[41:16];
        if (y > 26'sd8388607)
            y_sat = 24'sh7FFFFF;
        else if (y < -26'sd8388608)
            y_sat = -24'sh800000;
        else
            y_sat = y[23:0];
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign gain       = gain_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        x_reg    <= pop_entry.sample;
                        k_reg    <= lead;
                        m_reg    <= m_init;
                        frac_reg <= 16'd0;
                        cnt_reg  <= 4'd0;
                        if (pop_entry.envelope == 32'd0 || cfg.inv_ratio >= ONE_Q16)
                        begin
                            gain_reg  <= ONE_Q16;
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            state_reg <= B_LOG;
                        end
                    end
                end
                B_LOG:
                begin
                    m_reg    <= m_next;
                    frac_reg <= {frac_reg[14:0], sq[63]};
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= B_ATT;
                end
                B_ATT:
                begin
                    att_reg   <= att_prod[40:16];
                    state_reg <= B_DIFF;
                end
                B_DIFF:
                begin
                    if (diff[26] || diff == 27'sd0)
                    begin
                        gain_reg  <= ONE_Q16;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        excess_reg <= exc_prod[42:16];
                        state_reg  <= B_EXC;
                    end
                end
                B_EXC:
                begin
                    if (excess_reg == 27'd0)
                    begin
                        gain_reg  <= ONE_Q16;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        e_reg     <= e_prod[40:16];
                        g_reg     <= 33'h1_0000_0000;
                        cnt_reg   <= 4'd0;
                        state_reg <= B_EXP;
                    end
                end
                B_EXP:
                begin
                    // Multiply in one factor per set fraction bit, MSB first.
                    if (e_reg[4'd15 - cnt_reg])
                        g_reg <= g_prod[64:32];
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= B_SHIFT;
                end
                B_SHIFT:
                begin
                    gain_reg  <= (shift_n >= 9'd33) ? 17'd0 : g_shift[32:16];
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        sample_out_reg <= y_sat;
                        gain_out_reg   <= gain_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffac_checker.sv
// Port-level checker for the compressor and its bind.
`default_nettype none
`include "feedforward_audio_compressor_assert.svh"
module ffac_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [23:0] sample_out,
    input wire logic [16:0]        gain
);

    `FFAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(gain), "stalled result changed")
    `FFAC_ASSERT_NOW(a_gain_max, out_valid, gain <= 17'h10000, "gain above one")
    `FFAC_ASSERT_NOW(a_zero_gain, out_valid && gain == 17'd0, sample_out == 24'sd0, "zero gain with nonzero sample")
    `FFAC_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front took samples back to back")

endmodule

bind feedforward_audio_compressor ffac_checker u_ffac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .gain       (gain)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the feed-forward audio compressor.
module testbench
    import ffac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned SETTLE_CYCLES = 80;
    // No register lives at this index; a write to it must change nothing.
    localparam logic [7:0] CFG_UNUSED = 8'd5;

    typedef struct {
        logic signed [23:0] sample;
        logic [16:0]        gain;
    } comp_result_t;

    typedef struct {
        logic signed [23:0] sample;
        bit                 known;
        logic signed [23:0] sample_exp;
        logic [16:0]        gain_exp;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_index = 8'd0;
    logic [24:0]        cfg_data = 25'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [23:0] sample_in = 24'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [23:0] sample_out;
    logic [16:0]        gain;

    // Predictor copy of registers and state.
    logic [24:0]        rise_q24 = RISE_COEF_RST;
    logic [24:0]        fall_q24 = FALL_COEF_RST;
    logic signed [15:0] thresh_q8 = THRESHOLD_DB_RST;
    logic [16:0]        inv_ratio_q16 = INV_RATIO_RST;
    logic [31:0]        env_level = 32'd0;
    logic [31:0]        prev_power = 32'd0;
    bit                 env_rising = 1'b1;

    comp_result_t       pending_results[$];
    int unsigned        mismatches = 0;
    int unsigned        cycles = 0;
    bit                 calm_mode = 1'b0;

    feedforward_audio_compressor dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .gain       (gain)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bitwise integer square root, floor.
    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Attenuation -log2(env) in Q.16; env must be nonzero.
    function automatic logic [63:0] atten_log2_q16(input logic [31:0] env);
        int          lead;
        logic [63:0] mant;
        logic [63:0] frac;
        lead = 31;
        frac = 64'd0;
        while (env[lead] == 1'b0)
            lead--;
        mant = 64'(env) << (31 - lead);
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        return (64'(32 - lead) << 16) - frac;
    endfunction

    // Gain for e in Q.16: 2^(2^-i - 1) per set fraction bit i, shifted right by whole e; result Q0.16.
    function automatic logic [16:0] gain_from_octaves(input logic [63:0] e);
        logic [63:0] factor;
        logic [63:0] acc;
        logic [63:0] whole;
        factor = 64'd1 << 32;
        acc = 64'd1 << 32;
        whole = e >> 16;
        for (int i = 1; i <= 16; i++)
        begin
            factor = int_sqrt(factor << 31);
            if (e[16 - i])
                acc = (acc * factor) >> 32;
        end
        if (whole >= 33)
            return 17'd0;
        acc = acc >> whole;
        return 17'(acc >> 16);
    endfunction

    // Advance the predictor state by one sample and return its result.
    function automatic comp_result_t compress_sample(input logic signed [23:0] s);
        comp_result_t       res;
        logic signed [63:0] x;
        logic [63:0]        sq;
        logic [31:0]        power;
        logic [63:0]        coef;
        logic [16:0]        g;
        logic signed [63:0] att;
        logic signed [63:0] diff;
        logic [63:0]        excess;
        logic signed [63:0] prod;
        logic signed [63:0] y;
        x = 64'(s);
        sq = 64'(x * x) >> 14;
        power = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
        if (power > prev_power)
            env_rising = 1'b1;
        else if (power < prev_power)
            env_rising = 1'b0;
        prev_power = power;
        coef = env_rising ? 64'(rise_q24) : 64'(fall_q24);
        if (coef > 64'(ONE_Q24))
            coef = 64'(ONE_Q24);
        if (power >= env_level)
            env_level = env_level + 32'((64'(power - env_level) * coef) >> 24);
        else
            env_level = env_level - 32'((64'(env_level - power) * coef) >> 24);
        g = ONE_Q16;
        if (env_level != 0 && inv_ratio_q16 < ONE_Q16)
        begin
            att = $signed((atten_log2_q16(env_level) * 64'(DB_PER_OCTAVE_Q16)) >> 16);
            diff = -att - 64'(thresh_q8) * 256;
            if (diff > 0)
            begin
                excess = (64'(diff) * 64'(ONE_Q16 - inv_ratio_q16)) >> 16;
                if (excess > 0)
                    g = gain_from_octaves((excess * 64'(OCTAVE_PER_DB_Q16)) >> 16);
            end
        end
        prod = x * $signed({47'd0, g});
        y = prod >>> 16;
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        if (y < -64'sd8388608)
            y = -64'sd8388608;
        res.sample = y[23:0];
        res.gain = g;
        return res;
    endfunction

    // Pick an idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Hold the sample until the block takes it, then record the expectation.
    task automatic send_sample(input logic signed [23:0] s, input bit known,
                               input comp_result_t typed);
        int unsigned  gap;
        comp_result_t predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (in_stall);
        predicted = compress_sample(s);
        pending_results.push_back(known ? typed : predicted);
    endtask

    // Drop valid and wait until every result has drained.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [24:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RISE_COEF:    rise_q24 = data;
            CFG_FALL_COEF:    fall_q24 = data;
            CFG_THRESHOLD_DB: thresh_q8 = data[15:0];
            CFG_INV_RATIO:    inv_ratio_q16 = data[16:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [24:0] rise, input logic [24:0] fall,
                              input logic [15:0] thr, input logic [16:0] inv);
        write_reg(CFG_RISE_COEF, rise);
        write_reg(CFG_FALL_COEF, fall);
        write_reg(CFG_THRESHOLD_DB, {9'd0, thr});
        write_reg(CFG_INV_RATIO, {8'd0, inv});
        write_reg(CFG_UNUSED, 25'($urandom));
    endtask

    // Random samples in bursts of one loudness, so the envelope rises and falls.
    task automatic random_burst(input int unsigned count);
        comp_result_t       none;
        logic signed [23:0] s;
        logic signed [23:0] last;
        int unsigned        bits;
        int unsigned        r;
        none = '{sample: '0, gain: '0};
        last = 24'sd0;
        bits = $urandom_range(1, 24);
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 16 == 0)
                bits = $urandom_range(1, 24);
            if (n % 100 == 0)
                calm_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 60)
                s = $signed(24'($urandom)) >>> (24 - bits);
            else if (r < 75)
                s = 24'($urandom);
            else if (r < 85)
                s = ($urandom_range(0, 1) != 0) ? -last : last;
            else if (r < 92)
                s = ($urandom_range(0, 1) != 0) ? 24'sh800000 : 24'sh7FFFFF;
            else
                s = 24'sd0;
            send_sample(s, 1'b0, none);
            last = s;
        end
    endtask

    // Randomly stall the result side; calm stretches keep it open.
    always @(posedge clk)
    begin
        int unsigned hold;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (out_stall)
        begin
            if (hold == 0)
                out_stall <= 1'b0;
            else
                hold = hold - 1;
        end
        else if (!calm_mode && $urandom_range(0, 99) < 25)
        begin
            hold = pick_gap();
            out_stall <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        comp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sample %0d gain %0d", sample_out, gain);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.sample !== sample_out || want.gain !== gain)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sample exp %0d got %0d, gain exp %0d got %0d",
                                 want.sample, sample_out, want.gain, gain);
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Directed rows: only the first, at reset with a zero envelope, is read off directly.
    stim_row_t directed[16] = '{
        '{24'sd0,        1'b1, 24'sd0, 17'h10000},
        '{24'sh7FFFFF,   1'b0, 24'sd0, 17'd0},
        '{24'sh800000,   1'b0, 24'sd0, 17'd0},
        '{24'sh800000,   1'b0, 24'sd0, 17'd0},
        '{24'sh7FFFFF,   1'b0, 24'sd0, 17'd0},
        '{24'sd1,        1'b0, 24'sd0, 17'd0},
        '{-24'sd1,       1'b0, 24'sd0, 17'd0},
        '{24'sd0,        1'b0, 24'sd0, 17'd0},
        '{24'sh400000,   1'b0, 24'sd0, 17'd0},
        '{-24'sh400000,  1'b0, 24'sd0, 17'd0},
        '{24'sh555555,   1'b0, 24'sd0, 17'd0},
        '{24'shAAAAAA,   1'b0, 24'sd0, 17'd0},
        '{24'sd128,      1'b0, 24'sd0, 17'd0},
        '{24'sh7FFFFF,   1'b0, 24'sd0, 17'd0},
        '{24'sh7FFFFF,   1'b0, 24'sd0, 17'd0},
        '{24'sd0,        1'b0, 24'sd0, 17'd0}
    };

    initial
    begin
        comp_result_t typed;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with reset settings.
        foreach (directed[i])
        begin
            typed.sample = directed[i].sample_exp;
            typed.gain = directed[i].gain_exp;
            send_sample(directed[i].sample, directed[i].known, typed);
        end
        drain();

        // Instant envelope, threshold at 0 dB, infinite ratio.
        set_config(25'(ONE_Q24), 25'(ONE_Q24), 16'h0000, 17'd0);
        random_burst(RANDOM_ITEMS / 7);
        drain();

        // Coefficient above one, frozen fall, deepest threshold, ratio of one.
        set_config(25'h1FF_FFFF, 25'd0, 16'hA000, 17'(ONE_Q16));
        random_burst(RANDOM_ITEMS / 7);
        drain();

        // Ratio register above one, gain must stay at one.
        set_config(25'd50000, 25'd3000, 16'hC000, 17'h1FFFF);
        random_burst(RANDOM_ITEMS / 7);
        drain();

        // Heavy attenuation with a fast attack.
        set_config(25'(ONE_Q24), 25'd1000, 16'hA000, 17'd0);
        random_burst(RANDOM_ITEMS / 7);
        drain();

        // Random settings within the legal ranges.
        for (int p = 0; p < 2; p++)
        begin
            set_config(25'($urandom_range(0, 16777216)), 25'($urandom_range(0, 16777216)),
                       16'(-$signed(32'($urandom_range(0, 24576)))),
                       17'($urandom_range(0, 65535)));
            random_burst(RANDOM_ITEMS / 7);
            drain();
        end

        // Back to reset settings.
        set_config(RISE_COEF_RST, FALL_COEF_RST, THRESHOLD_DB_RST, INV_RATIO_RST);
        random_burst(RANDOM_ITEMS / 7);
        drain();

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
